// ===== hw/rtl/pf_pkg.sv =====
// Shared types, constants and letter helpers for the Playfair digraph cipher.
// No dependencies; the cipher modules and the testbench import this package.
`default_nettype none

package pf_pkg;

    // Grid geometry and filler letter (X as a letter code, J left out)
    localparam int          LETTER_COUNT = 25;
    localparam logic [4:0]  FILLER_CODE  = 5'd22;
    localparam logic [4:0]  LAST_CODE    = 5'd24;
    localparam logic [4:0]  GRID_FULL    = 5'd25;
    localparam int          QUEUE_DEPTH  = 2;

    // Action codes of the input stream
    typedef enum logic [2:0] {
        ACT_CLEAR     = 3'd0,
        ACT_KEY       = 3'd1,
        ACT_KEY_DONE  = 3'd2,
        ACT_PLAIN     = 3'd3,
        ACT_PLAIN_END = 3'd4,
        ACT_CIPHER    = 3'd5
    } t_act;

    // Classified command handed from the front to the back
    typedef struct packed {
        t_act       act;
        logic       code_ok;
        logic [4:0] code;
    } t_cmd;

    // One result pair
    typedef struct packed {
        logic [6:0] first_letter;
        logic [6:0] second_letter;
        logic       is_decrypt;
        logic       not_ready_error;
    } t_result;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FILL,
        BK_LOOK,
        BK_GRID
    } t_back_state;

    // Letter filter: {valid, code 0..24}; folds case, J becomes I
    function automatic logic [5:0] letter_code(input logic [7:0] b);
        logic [7:0] c;
        logic [4:0] k;
        c = b;
        if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'd32;
        end
        if (c == 8'h4A) begin
            c = 8'h49;
        end
        k = 5'(c - 8'h41);
        if (k > 5'd9) begin
            k = k - 5'd1;
        end
        letter_code = {(c >= 8'h41 && c <= 8'h5A), k};
    endfunction

    // Letter code back to upper-case ASCII
    function automatic logic [6:0] code_ascii(input logic [4:0] code);
        code_ascii = {2'b00, code} + ((code < 5'd9) ? 7'd65 : 7'd66);
    endfunction

    // Row of a cell 0..24: (c * 13) >> 6 is exact over that range
    function automatic logic [2:0] cell_row(input logic [4:0] c);
        logic [8:0] p;
        p = {4'b0000, c} * 9'd13;
        cell_row = p[8:6];
    endfunction

    // Column of a cell 0..24
    function automatic logic [2:0] cell_col(input logic [4:0] c);
        logic [2:0] r;
        logic [4:0] b;
        r = cell_row(c);
        b = {r, 2'b00} + {2'b00, r};
        cell_col = 3'(c - b);
    endfunction

    // Cell index from row and column
    function automatic logic [4:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
        cell_idx = {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    // Step one place forward or back, modulo five
    function automatic logic [2:0] step5(input logic [2:0] v, input logic back);
        if (back) begin
            step5 = (v == 3'd0) ? 3'd4 : v - 3'd1;
        end else begin
            step5 = (v == 3'd4) ? 3'd0 : v + 3'd1;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pf_in_if.sv =====
// Input stream interface: one action and one raw byte per transaction.
// No dependencies.
`default_nettype none

interface pf_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] char_code;

    modport source (output valid, output action, output char_code, input ready);
    modport sink   (input valid, input action, input char_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pf_out_if.sv =====
// Result stream interface: one letter pair with flags per transaction.
// No dependencies.
`default_nettype none

interface pf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] first_letter;
    logic [6:0] second_letter;
    logic       is_decrypt;
    logic       not_ready_error;

    modport source (output valid, output first_letter, output second_letter,
                    output is_decrypt, output not_ready_error, input ready);
    modport sink   (input valid, input first_letter, input second_letter,
                    input is_decrypt, input not_ready_error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/playfair_digraph_cipher.sv =====
// Top level of the Playfair digraph cipher: front, command queue and back.
// Depends on pf_pkg, pf_in_if, pf_out_if, pf_front, pf_queue and pf_back.
`default_nettype none

// Playfair cipher on a 5x5 key grid (I and J share a cell). The input side
// takes one transaction per cycle into a short command queue while the queue
// has room. The back end handles clear, a key byte, or a text letter that
// only becomes pending within its idle state; a letter that completes a pair,
// or plain end with a letter pending, passes through cell lookup, grid lookup
// and result register, set by the two registered reads of the grid memories.
// Key done starts a walk that places the unused letters in alphabet order, one
// letter a cycle. Text sent before key done returns a single result flagged
// not_ready_error with zero letters. Results sit in an output register, so one
// result may wait while the queue fills.
module playfair_digraph_cipher #(
    parameter int QUEUE_DEPTH = pf_pkg::QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pf_in_if.sink       i_in,
    pf_out_if.source    o_out
);
    import pf_pkg::*;

    logic    f_valid, f_ready;
    t_cmd    f_cmd;
    logic    q_valid, q_ready;
    t_cmd    q_cmd;
    t_result res;

    pf_front u_front (
        .i_in        (i_in),
        .o_cmd_valid (f_valid),
        .o_cmd       (f_cmd),
        .i_cmd_ready (f_ready)
    );

    pf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    pf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_res_valid (o_out.valid),
        .i_res_ready (o_out.ready),
        .o_res       (res)
    );

    // Result payload onto the output channel
    assign o_out.first_letter    = res.first_letter;
    assign o_out.second_letter   = res.second_letter;
    assign o_out.is_decrypt      = res.is_decrypt;
    assign o_out.not_ready_error = res.not_ready_error;

endmodule

`default_nettype wire

// ===== hw/rtl/pf_front.sv =====
// Front end: filters the raw byte and classifies each input transaction.
// Depends on pf_pkg and pf_in_if.
`default_nettype none

module pf_front (
    pf_in_if.sink       i_in,
    output logic        o_cmd_valid,
    output pf_pkg::t_cmd o_cmd,
    input  wire logic   i_cmd_ready
);
    import pf_pkg::*;

    logic [5:0] lc;
    logic       keep;

    assign lc = letter_code(i_in.char_code);

    // Unknown actions and non-letter key bytes are consumed here
    always_comb begin
        keep = 1'b0;
        unique case (i_in.action) inside
            ACT_CLEAR, ACT_KEY_DONE, ACT_PLAIN, ACT_PLAIN_END, ACT_CIPHER: keep = 1'b1;
            ACT_KEY: keep = lc[5];
            default: keep = 1'b0;
        endcase
    end

    assign o_cmd.act     = t_act'(i_in.action);
    assign o_cmd.code_ok = lc[5];
    assign o_cmd.code    = lc[4:0];
    assign o_cmd_valid   = i_in.valid & keep;
    assign i_in.ready    = i_cmd_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/pf_queue.sv =====
// Short command queue between front and back so each can stall alone.
// Depends on pf_pkg.
`default_nettype none

module pf_queue #(
    parameter int DEPTH = pf_pkg::QUEUE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push_valid,
    output logic         o_push_ready,
    input  pf_pkg::t_cmd i_push_cmd,
    output logic         o_pop_valid,
    input  wire logic    i_pop_ready,
    output pf_pkg::t_cmd o_pop_cmd
);
    import pf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pf_back.sv =====
// Back end: owns the key grid and pending letters, builds and transforms pairs.
// Depends on pf_pkg.
`default_nettype none

module pf_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    output logic            o_cmd_ready,
    input  pf_pkg::t_cmd    i_cmd,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output pf_pkg::t_result o_res
);
    import pf_pkg::*;

    // Grid stores: cell -> letter and letter -> cell
    logic [4:0]  r_grid [LETTER_COUNT];
    logic [4:0]  r_cell [LETTER_COUNT];

    t_back_state r_state, n_state;
    logic [24:0] r_used, n_used;
    logic [4:0]  r_fill, n_fill;
    logic        r_ready, n_ready;
    logic [4:0]  r_ppend, n_ppend;
    logic        r_ppv, n_ppv;
    logic [4:0]  r_cpend, n_cpend;
    logic        r_cpv, n_cpv;
    logic [4:0]  r_walk, n_walk;
    logic        r_dec, n_dec;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic [4:0]  r_ca, r_cb, r_ga, r_gb;
    logic [4:0]  rd_a, rd_b, g_a, g_b;
    logic        place_en;
    logic [4:0]  place_code;
    logic        slot_free;
    logic [2:0]  r1, c1, r2, c2;

    assign slot_free   = !r_out_valid || i_res_ready;
    assign o_cmd_ready = (r_state == BK_IDLE) && slot_free;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Sequencer: next state, grid fill and pair setup
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_fill      = r_fill;
        n_ready     = r_ready;
        n_ppend     = r_ppend;
        n_ppv       = r_ppv;
        n_cpend     = r_cpend;
        n_cpv       = r_cpv;
        n_walk      = r_walk;
        n_dec       = r_dec;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        rd_a        = i_cmd.code;
        rd_b        = i_cmd.code;
        place_code  = i_cmd.code;
        place_en    = 1'b0;
        r1          = cell_row(r_ca);
        c1          = cell_col(r_ca);
        r2          = cell_row(r_cb);
        c2          = cell_col(r_cb);

        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    unique case (i_cmd.act) inside
                        ACT_CLEAR: begin
                            n_used  = '0;
                            n_fill  = '0;
                            n_ready = 1'b0;
                            n_ppend = '0;
                            n_ppv   = 1'b0;
                            n_cpend = '0;
                            n_cpv   = 1'b0;
                        end
                        ACT_KEY: begin
                            place_en = !r_ready && i_cmd.code_ok &&
                                       !r_used[place_code] && (r_fill < GRID_FULL);
                        end
                        ACT_KEY_DONE: begin
                            if (!r_ready) begin
                                n_walk  = '0;
                                n_state = BK_FILL;
                            end
                        end
                        ACT_PLAIN, ACT_PLAIN_END, ACT_CIPHER: begin
                            if (!r_ready) begin
                                // text before the grid is complete
                                n_out_valid           = 1'b1;
                                n_out.first_letter    = '0;
                                n_out.second_letter   = '0;
                                n_out.is_decrypt      = (i_cmd.act == ACT_CIPHER);
                                n_out.not_ready_error = 1'b1;
                            end else if (i_cmd.act == ACT_PLAIN_END) begin
                                if (r_ppv) begin
                                    rd_a    = r_ppend;
                                    rd_b    = FILLER_CODE;
                                    n_dec   = 1'b0;
                                    n_ppv   = 1'b0;
                                    n_ppend = '0;
                                    n_state = BK_LOOK;
                                end
                            end else if (i_cmd.code_ok) begin
                                if (i_cmd.act == ACT_PLAIN) begin
                                    if (!r_ppv) begin
                                        n_ppend = i_cmd.code;
                                        n_ppv   = 1'b1;
                                    end else if (r_ppend == i_cmd.code) begin
                                        // doubled letter: pair with X, keep it pending
                                        rd_a    = r_ppend;
                                        rd_b    = FILLER_CODE;
                                        n_dec   = 1'b0;
                                        n_state = BK_LOOK;
                                    end else begin
                                        rd_a    = r_ppend;
                                        rd_b    = i_cmd.code;
                                        n_dec   = 1'b0;
                                        n_ppv   = 1'b0;
                                        n_ppend = '0;
                                        n_state = BK_LOOK;
                                    end
                                end else begin
                                    if (!r_cpv) begin
                                        n_cpend = i_cmd.code;
                                        n_cpv   = 1'b1;
                                    end else begin
                                        rd_a    = r_cpend;
                                        rd_b    = i_cmd.code;
                                        n_dec   = 1'b1;
                                        n_cpv   = 1'b0;
                                        n_cpend = '0;
                                        n_state = BK_LOOK;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_FILL: begin
                // key done: place the remaining letters in alphabet order
                place_code = r_walk;
                place_en   = !r_used[place_code] && (r_fill < GRID_FULL);
                n_walk     = r_walk + 5'd1;
                if (r_walk == LAST_CODE) begin
                    n_ready = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            BK_LOOK: begin
                // row, column and rectangle rules on the looked-up cells
                if (r1 == r2) begin
                    c1 = step5(c1, r_dec);
                    c2 = step5(c2, r_dec);
                end else if (c1 == c2) begin
                    r1 = step5(r1, r_dec);
                    r2 = step5(r2, r_dec);
                end else begin
                    c1 = cell_col(r_cb);
                    c2 = cell_col(r_ca);
                end
                n_state = BK_GRID;
            end
            BK_GRID: begin
                n_out_valid           = 1'b1;
                n_out.first_letter    = code_ascii(r_ga);
                n_out.second_letter   = code_ascii(r_gb);
                n_out.is_decrypt      = r_dec;
                n_out.not_ready_error = 1'b0;
                n_state               = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase

        if (place_en) begin
            n_used[place_code] = 1'b1;
            n_fill             = r_fill + 5'd1;
        end
    end

    assign g_a = cell_idx(r1, c1);
    assign g_b = cell_idx(r2, c2);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_used      <= '0;
            r_fill      <= '0;
            r_ready     <= 1'b0;
            r_ppend     <= '0;
            r_ppv       <= 1'b0;
            r_cpend     <= '0;
            r_cpv       <= 1'b0;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_fill      <= n_fill;
            r_ready     <= n_ready;
            r_ppend     <= n_ppend;
            r_ppv       <= n_ppv;
            r_cpend     <= n_cpend;
            r_cpv       <= n_cpv;
            r_walk      <= n_walk;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_dec <= n_dec;
        r_out <= n_out;
    end

    // Grid memories: one write port, two registered read ports each
    always_ff @(posedge i_clk) begin
        if (place_en) begin
            r_grid[r_fill]     <= place_code;
            r_cell[place_code] <= r_fill;
        end
        r_ca <= r_cell[rd_a];
        r_cb <= r_cell[rd_b];
        r_ga <= r_grid[g_a];
        r_gb <= r_grid[g_b];
    end

endmodule

`default_nettype wire

// ===== tb/tb_playfair_digraph_cipher.sv =====
// Self-checking testbench for the Playfair digraph cipher top level.
// Depends on pf_pkg, pf_in_if, pf_out_if and the playfair_digraph_cipher RTL.
`timescale 1ns / 1ps

module tb_playfair_digraph_cipher;
    import pf_pkg::*;

    // Actions the block must ignore
    localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    // ASCII bounds for the letter filter
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_I = 8'h49;
    localparam logic [7:0] CH_UP_J = 8'h4A;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;

    localparam logic [4:0] X_CODE        = 5'd22;  // X, J left out of the alphabet
    localparam int         GRID_CELLS    = 25;
    localparam int         RX_HOLD_CYCLES = 300;
    localparam int         IDLE_LIMIT     = 4000;
    localparam int         DRAIN_CYCLES   = 64;

    logic i_clk;
    logic i_rst_n;

    pf_in_if  in_bus();
    pf_out_if out_bus();

    playfair_digraph_cipher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Handshake pressure knobs, percent of cycles
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit stall_request = 1'b0;

    // Scoreboard bookkeeping
    t_result expected_pairs[$];
    int      mismatches     = 0;
    int      pairs_checked  = 0;
    int      items_accepted = 0;
    int      text_items     = 0;

    // Shadow copy of the cipher state
    logic [4:0]  grid_at [GRID_CELLS];
    logic [4:0]  cell_of [GRID_CELLS];
    logic [24:0] placed;
    int          filled;
    bit          grid_done;
    logic [4:0]  plain_hold;
    bit          plain_held;
    logic [4:0]  cipher_hold;
    bit          cipher_held;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Cipher predictor
    // ---------------------------------------------------------------

    function automatic void clear_grid();
        for (int i = 0; i < GRID_CELLS; i++) begin
            grid_at[i] = '0;
            cell_of[i] = '0;
        end
        placed      = '0;
        filled      = 0;
        grid_done   = 1'b0;
        plain_hold  = '0;
        plain_held  = 1'b0;
        cipher_hold = '0;
        cipher_held = 1'b0;
    endfunction

    // Byte to letter index 0..24, -1 for non-letters
    function automatic int letter_index(input logic [7:0] b);
        logic [7:0] c;
        int k;
        c = b;
        if (c >= CH_LO_A && c <= CH_LO_Z) c = c - 8'd32;
        if (c < CH_UP_A || c > CH_UP_Z) return -1;
        if (c == CH_UP_J) c = CH_UP_I;
        k = int'(c - CH_UP_A);
        return (k > 9) ? k - 1 : k;
    endfunction

    function automatic logic [6:0] index_to_ascii(input logic [4:0] k);
        int v;
        v = (k < 9) ? int'(k) : int'(k) + 1;
        return 7'(v + int'(CH_UP_A));
    endfunction

    function automatic void place_letter(input int k);
        if (filled >= GRID_CELLS || placed[k]) return;
        placed[k]       = 1'b1;
        grid_at[filled] = 5'(k);
        cell_of[k]      = 5'(filled);
        filled++;
    endfunction

    // Row, column and rectangle rules; decryption steps back one place
    function automatic t_result cipher_pair(input logic [4:0] a, input logic [4:0] b,
                                            input bit decrypt);
        t_result res;
        int shift, r1, c1, r2, c2, t;
        shift = decrypt ? 4 : 1;
        r1 = int'(cell_of[a]) / 5;
        c1 = int'(cell_of[a]) % 5;
        r2 = int'(cell_of[b]) / 5;
        c2 = int'(cell_of[b]) % 5;
        if (r1 == r2) begin
            c1 = (c1 + shift) % 5;
            c2 = (c2 + shift) % 5;
        end else if (c1 == c2) begin
            r1 = (r1 + shift) % 5;
            r2 = (r2 + shift) % 5;
        end else begin
            t  = c1;
            c1 = c2;
            c2 = t;
        end
        res.first_letter    = index_to_ascii(grid_at[r1 * 5 + c1]);
        res.second_letter   = index_to_ascii(grid_at[r2 * 5 + c2]);
        res.is_decrypt      = decrypt;
        res.not_ready_error = 1'b0;
        return res;
    endfunction

    // Advance the shadow state by one transaction; returns 1 with a pair
    function automatic bit playfair_step(input logic [2:0] act, input logic [7:0] ch,
                                         output t_result res);
        int k;
        k   = letter_index(ch);
        res = '0;
        case (act) inside
            ACT_CLEAR: begin
                clear_grid();
                return 1'b0;
            end
            ACT_KEY: begin
                if (!grid_done && k >= 0) place_letter(k);
                return 1'b0;
            end
            ACT_KEY_DONE: begin
                if (!grid_done) begin
                    for (int i = 0; i < GRID_CELLS; i++) place_letter(i);
                    grid_done = 1'b1;
                end
                return 1'b0;
            end
            ACT_PLAIN, ACT_PLAIN_END, ACT_CIPHER: begin
                if (!grid_done) begin
                    res.is_decrypt      = (act == ACT_CIPHER);
                    res.not_ready_error = 1'b1;
                    return 1'b1;
                end
            end
            default: return 1'b0;
        endcase

        if (act == ACT_PLAIN_END) begin
            if (!plain_held) return 1'b0;
            res        = cipher_pair(plain_hold, X_CODE, 1'b0);
            plain_held = 1'b0;
            plain_hold = '0;
            return 1'b1;
        end
        if (k < 0) return 1'b0;
        if (act == ACT_PLAIN) begin
            if (!plain_held) begin
                plain_hold = 5'(k);
                plain_held = 1'b1;
                return 1'b0;
            end
            // doubled letter: pair with X, the new letter stays pending
            if (plain_hold == 5'(k)) begin
                res = cipher_pair(plain_hold, X_CODE, 1'b0);
                return 1'b1;
            end
            res        = cipher_pair(plain_hold, 5'(k), 1'b0);
            plain_held = 1'b0;
            plain_hold = '0;
            return 1'b1;
        end
        if (!cipher_held) begin
            cipher_hold = 5'(k);
            cipher_held = 1'b1;
            return 1'b0;
        end
        res         = cipher_pair(cipher_hold, 5'(k), 1'b1);
        cipher_held = 1'b0;
        cipher_hold = '0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Scoreboard: check results first, then predict accepted input
    // ---------------------------------------------------------------

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
                got.first_letter    = out_bus.first_letter;
                got.second_letter   = out_bus.second_letter;
                got.is_decrypt      = out_bus.is_decrypt;
                got.not_ready_error = out_bus.not_ready_error;
                pairs_checked++;
                if (expected_pairs.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_pairs.pop_front();
                    check_field("first_letter", want.first_letter, got.first_letter);
                    check_field("second_letter", want.second_letter, got.second_letter);
                    check_field("is_decrypt", want.is_decrypt, got.is_decrypt);
                    check_field("not_ready_error", want.not_ready_error,
                                got.not_ready_error);
                end
            end
            if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
                items_accepted++;
                if (playfair_step(in_bus.action, in_bus.char_code, want))
                    expected_pairs.push_back(want);
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
            (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stalls, or one long hold on request
    initial begin : receiver
        int held;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                out_bus.ready <= 1'b0;
                for (held = 1; held < RX_HOLD_CYCLES; held++) @(negedge i_clk);
                stall_request = 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Offer one transaction; returns just after the edge that takes it
    task automatic send_item(input logic [2:0] act, input logic [7:0] ch);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        in_bus.valid     <= 1'b1;
        in_bus.action    <= act;
        in_bus.char_code <= ch;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        if (act >= ACT_KEY && act <= ACT_CIPHER) text_items++;
    endtask

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = CH_UP_A + 8'($urandom_range(25));
        if ($urandom_range(1)) c = c + 8'd32;
        return c;
    endfunction

    function automatic logic [7:0] random_text_byte();
        return ($urandom_range(99) < 85) ? random_letter() : 8'($urandom_range(255));
    endfunction

    // One key setup followed by a burst of mixed text
    task automatic run_session();
        int n;
        int r;
        logic [7:0] last_plain;
        logic [7:0] ch;
        logic [2:0] act;
        send_item(ACT_CLEAR, 8'($urandom_range(255)));
        n = $urandom_range(12);
        repeat (n) send_item(ACT_KEY, random_text_byte());
        // occasional text before the grid is complete
        if ($urandom_range(9) == 0) begin
            act = ACT_PLAIN;
            act = act + 3'($urandom_range(2));
            send_item(act, random_text_byte());
        end
        send_item(ACT_KEY_DONE, 8'($urandom_range(255)));
        last_plain = random_letter();
        n = $urandom_range(4, 30);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 45) begin
                ch = ($urandom_range(3) == 0) ? last_plain : random_text_byte();
                send_item(ACT_PLAIN, ch);
                last_plain = ch;
            end else if (r < 55) begin
                send_item(ACT_PLAIN_END, 8'($urandom_range(255)));
            end else if (r < 90) begin
                send_item(ACT_CIPHER, random_text_byte());
            end else if (r < 95) begin
                act = $urandom_range(1) ? ACT_KEY : ACT_KEY_DONE;
                send_item(act, random_text_byte());
            end else begin
                act = $urandom_range(1) ? ACT_UNUSED_LO : ACT_UNUSED_HI;
                send_item(act, 8'($urandom_range(255)));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Text with no grid gives flagged results; spare actions do nothing
    task automatic test_text_before_grid();
        send_item(ACT_PLAIN, "A");
        send_item(ACT_PLAIN_END, 8'h00);
        send_item(ACT_CIPHER, "z");
        send_item(ACT_UNUSED_LO, 8'hFF);
        send_item(ACT_UNUSED_HI, 8'h00);
    endtask

    // Key with mixed case, J folding, repeats and junk; late key ignored
    task automatic test_key_build();
        send_item(ACT_KEY, "P");
        send_item(ACT_KEY, "l");
        send_item(ACT_KEY, "a");
        send_item(ACT_KEY, "Y");
        send_item(ACT_KEY, "j");
        send_item(ACT_KEY, "y");
        send_item(ACT_KEY, 8'h00);
        send_item(ACT_KEY_DONE, 8'hFF);
        send_item(ACT_KEY, "Q");
        send_item(ACT_KEY_DONE, "Z");
    endtask

    // Doubled X, rectangle pair, junk, empty and padded plain end
    task automatic test_plain_rules();
        send_item(ACT_PLAIN, "x");
        send_item(ACT_PLAIN, "X");
        send_item(ACT_PLAIN, "A");
        send_item(ACT_PLAIN, 8'h7B);
        send_item(ACT_PLAIN_END, 8'h00);
        send_item(ACT_PLAIN, "Z");
        send_item(ACT_PLAIN_END, 8'hFF);
    endtask

    // Column pair decrypts upward; a lone letter is dropped by clear
    task automatic test_cipher_rules();
        send_item(ACT_CIPHER, "p");
        send_item(ACT_CIPHER, 8'h40);
        send_item(ACT_CIPHER, "G");
        send_item(ACT_CIPHER, "k");
        send_item(ACT_CLEAR, 8'h00);
    endtask

    // Random sessions under one handshake pattern
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int stop_at;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        stop_at      = text_items + count;
        while (text_items < stop_at) run_session();
    endtask

    // Long result hold while text keeps coming, so the input side stalls
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_item(ACT_CLEAR, 8'h00);
        send_item(ACT_KEY_DONE, 8'h00);
        stall_request = 1'b1;
        repeat (24) send_item(ACT_PLAIN, random_letter());
        send_item(ACT_PLAIN_END, 8'h00);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n          = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.action    = ACT_CLEAR;
        in_bus.char_code = 8'h00;
        clear_grid();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_text_before_grid();
        test_key_build();
        test_plain_rules();
        test_cipher_rules();
        test_random_traffic(0, 0, 175);
        test_random_traffic(81, 0, 175);
        test_random_traffic(0, 81, 175);
        test_random_traffic(7, 7, 175);
        test_output_backpressure();

        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions (%0d key/text), checked %0d result pairs",
                 items_accepted, text_items, pairs_checked);
        $display("Covered early text, key filtering, all pair rules, four stall mixes, long hold");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
